### rtl/mff_pkg.sv
// ----------------------------------------------------------------------------
// mff_pkg
// Shared types and constants for the multichannel frame FIFO: field widths,
// command codes, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mff_pkg;

    localparam int CMD_W       = 3;
    localparam int FRAME_W     = 6;
    localparam int SAMPLE_W    = 32;
    localparam int CAP_CFG_W   = 11;
    localparam int CH_CFG_W    = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CAP_CFG_W-1:0] CAP_CFG_RESET = 11'd1024;
    localparam logic [CH_CFG_W-1:0]  CH_CFG_RESET  = 2'd2;
    localparam int                   CAP_MIN       = 2;
    localparam int                   CH_MIN        = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CAPACITY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CHANNELS = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_BEGIN  = 3'd0,
        CMD_WRITE_SAMPLE = 3'd1,
        CMD_READ         = 3'd2,
        CMD_PEEK         = 3'd3,
        CMD_CLEAR        = 3'd4
    } t_command;

    // Datapath operation for the current cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_WBEGIN,
        OP_WSAMPLE,
        OP_STRAY,
        OP_READ_START,
        OP_PEEK_START,
        OP_RD_EMPTY,
        OP_RD_NEXT,
        OP_RD_LAST,
        OP_CLEAR,
        OP_UNKNOWN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic out_free;       // result register empty or being taken
        logic pending_zero;   // no write open
        logic avail_zero;     // read/peek would move no frames
        logic remaining_one;  // next sample is the final one of the run
    } t_sts;

endpackage

### rtl/mff_ram.sv
// ----------------------------------------------------------------------------
// mff_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mff_ctrl.sv
// ----------------------------------------------------------------------------
// mff_ctrl
// Request sequencer: decodes the accepted command into a datapath operation
// and steps through the sample run of a read or peek.
// ----------------------------------------------------------------------------
module mff_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [mff_pkg::CMD_W-1:0]  i_command,
    input  mff_pkg::t_sts              i_sts,
    output mff_pkg::t_ctl              o_ctl
);
    import mff_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;
    t_ctl   ctl;

    always_comb begin
        n_state    = r_state;
        ctl.op     = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    case (i_command)
                        CMD_WRITE_BEGIN:  ctl.op = OP_WBEGIN;
                        CMD_WRITE_SAMPLE: ctl.op = i_sts.pending_zero ? OP_STRAY : OP_WSAMPLE;
                        CMD_READ: begin
                            if (i_sts.avail_zero) begin
                                ctl.op = OP_RD_EMPTY;
                            end else begin
                                ctl.op  = OP_READ_START;
                                n_state = S_READ;
                            end
                        end
                        CMD_PEEK: begin
                            if (i_sts.avail_zero) begin
                                ctl.op = OP_RD_EMPTY;
                            end else begin
                                ctl.op  = OP_PEEK_START;
                                n_state = S_READ;
                            end
                        end
                        CMD_CLEAR:        ctl.op = OP_CLEAR;
                        default:          ctl.op = OP_UNKNOWN;
                    endcase
                end
            end
            S_READ: begin
                if (i_sts.out_free) begin
                    if (i_sts.remaining_one) begin
                        ctl.op  = OP_RD_LAST;
                        n_state = S_IDLE;
                    end else begin
                        ctl.op = OP_RD_NEXT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl = ctl;

endmodule

### rtl/mff_dp.sv
// ----------------------------------------------------------------------------
// mff_dp
// FIFO datapath: configuration registers, ring pointers, open-write staging,
// frame occupancy, sample store and the result register.
// ----------------------------------------------------------------------------
module mff_dp #(
    parameter int CAPACITY_FRAMES    = 1024,
    parameter int MAX_CHANNELS       = 2,
    parameter int MAX_REQUEST_FRAMES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mff_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mff_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [mff_pkg::FRAME_W-1:0]      i_frame_count,
    input  logic [mff_pkg::SAMPLE_W-1:0]     i_sample,
    input  mff_pkg::t_ctl                    i_ctl,
    output mff_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mff_pkg::FRAME_W-1:0]      o_frames_done,
    output logic [mff_pkg::SAMPLE_W-1:0]     o_sample_res,
    output logic                             o_sample_valid,
    output logic                             o_last,
    output logic                             o_status
);
    import mff_pkg::*;

    localparam int STORE_DEPTH = CAPACITY_FRAMES * MAX_CHANNELS;
    localparam int IW = $clog2(STORE_DEPTH);
    localparam int RW = $clog2(STORE_DEPTH + 1);
    localparam int FW = $clog2(CAPACITY_FRAMES + 1);
    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int QW = $clog2(MAX_REQUEST_FRAMES + 1);
    localparam int PW = $clog2(MAX_REQUEST_FRAMES * MAX_CHANNELS + 1);

    // Configuration and control state
    logic [CAP_CFG_W-1:0] r_cap_cfg, n_cap_cfg;
    logic [CH_CFG_W-1:0]  r_ch_cfg,  n_ch_cfg;
    logic [IW-1:0]        r_wr_idx,  n_wr_idx;
    logic [IW-1:0]        r_rd_idx,  n_rd_idx;
    logic [IW-1:0]        r_stage,   n_stage;
    logic [IW-1:0]        r_pos,     n_pos;
    logic [PW-1:0]        r_pending, n_pending;
    logic [PW-1:0]        r_remain,  n_remain;
    logic [QW-1:0]        r_open_frames, n_open_frames;
    logic [QW-1:0]        r_rd_n,    n_rd_n;
    logic [FW-1:0]        r_used,    n_used;
    logic                 r_consume, n_consume;
    logic                 r_out_valid, n_out_valid;

    // Result payload
    logic [FRAME_W-1:0]   r_frames_done, n_frames_done;
    logic [SAMPLE_W-1:0]  r_sample_res,  n_sample_res;
    logic                 r_sample_valid, n_sample_valid;
    logic                 r_last,   n_last;
    logic                 r_status, n_status;
    logic                 out_load;

    logic [FW-1:0]        eff_cap;
    logic [CW-1:0]        eff_ch;
    logic [RW-1:0]        ring;
    logic [QW-1:0]        req_c;
    logic [FW-1:0]        space;
    logic [QW-1:0]        wb_n;
    logic [QW-1:0]        rd_n;
    logic [PW-1:0]        wb_samples;
    logic [PW-1:0]        rd_samples;
    logic [IW-1:0]        stage_nxt;

    logic                 ram_we;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic [SAMPLE_W-1:0]  ram_rdata;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx,
                                                input logic [RW-1:0] size);
        logic [RW-1:0] nxt;
        nxt = RW'(idx) + RW'(1);
        return (nxt == size) ? '0 : IW'(nxt);
    endfunction

    // Effective configuration, clamped into range
    always_comb begin
        if (32'(r_cap_cfg) < CAP_MIN) begin
            eff_cap = FW'(CAP_MIN);
        end else if (32'(r_cap_cfg) > CAPACITY_FRAMES) begin
            eff_cap = FW'(CAPACITY_FRAMES);
        end else begin
            eff_cap = FW'(r_cap_cfg);
        end
        if (32'(r_ch_cfg) < CH_MIN) begin
            eff_ch = CW'(CH_MIN);
        end else if (32'(r_ch_cfg) > MAX_CHANNELS) begin
            eff_ch = CW'(MAX_CHANNELS);
        end else begin
            eff_ch = CW'(r_ch_cfg);
        end
    end

    assign ring  = RW'(eff_cap) * RW'(eff_ch);
    assign req_c = (32'(i_frame_count) > MAX_REQUEST_FRAMES) ? QW'(MAX_REQUEST_FRAMES)
                                                             : QW'(i_frame_count);
    assign space = eff_cap - r_used - FW'(1);
    assign wb_n  = (32'(req_c) < 32'(space))  ? req_c : QW'(space);
    assign rd_n  = (32'(req_c) < 32'(r_used)) ? req_c : QW'(r_used);
    assign wb_samples = PW'(wb_n) * PW'(eff_ch);
    assign rd_samples = PW'(rd_n) * PW'(eff_ch);
    assign stage_nxt  = ring_next(r_stage, ring);

    always_comb begin
        n_cap_cfg      = r_cap_cfg;
        n_ch_cfg       = r_ch_cfg;
        n_wr_idx       = r_wr_idx;
        n_rd_idx       = r_rd_idx;
        n_stage        = r_stage;
        n_pos          = r_pos;
        n_pending      = r_pending;
        n_remain       = r_remain;
        n_open_frames  = r_open_frames;
        n_rd_n         = r_rd_n;
        n_used         = r_used;
        n_consume      = r_consume;
        n_frames_done  = '0;
        n_sample_res   = '0;
        n_sample_valid = 1'b0;
        n_last         = 1'b1;
        n_status       = 1'b0;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = r_pos;

        case (i_ctl.op)
            OP_WBEGIN: begin
                // a fresh begin drops any uncommitted samples
                n_pending     = wb_samples;
                n_open_frames = wb_n;
                n_stage       = r_wr_idx;
                n_frames_done = FRAME_W'(wb_n);
                out_load      = 1'b1;
            end
            OP_WSAMPLE: begin
                ram_we    = 1'b1;
                n_stage   = stage_nxt;
                n_pending = r_pending - PW'(1);
                if (r_pending == PW'(1)) begin
                    n_wr_idx = stage_nxt;
                    n_used   = r_used + FW'(r_open_frames);
                end
                out_load = 1'b1;
            end
            OP_STRAY: begin
                n_status = 1'b1;
                out_load = 1'b1;
            end
            OP_READ_START, OP_PEEK_START: begin
                ram_re    = 1'b1;
                ram_raddr = r_rd_idx;
                n_pos     = ring_next(r_rd_idx, ring);
                n_remain  = rd_samples;
                n_rd_n    = rd_n;
                n_consume = (i_ctl.op == OP_READ_START);
            end
            OP_RD_NEXT: begin
                // hand over the current word and fetch the following one
                ram_re         = 1'b1;
                ram_raddr      = r_pos;
                n_pos          = ring_next(r_pos, ring);
                n_remain       = r_remain - PW'(1);
                n_frames_done  = FRAME_W'(r_rd_n);
                n_sample_res   = ram_rdata;
                n_sample_valid = 1'b1;
                n_last         = 1'b0;
                out_load       = 1'b1;
            end
            OP_RD_LAST: begin
                n_remain       = r_remain - PW'(1);
                n_frames_done  = FRAME_W'(r_rd_n);
                n_sample_res   = ram_rdata;
                n_sample_valid = 1'b1;
                out_load       = 1'b1;
                if (r_consume) begin
                    n_rd_idx = r_pos;
                    n_used   = r_used - FW'(r_rd_n);
                end
            end
            OP_RD_EMPTY, OP_UNKNOWN: begin
                out_load = 1'b1;
            end
            OP_CLEAR: begin
                n_wr_idx  = '0;
                n_rd_idx  = '0;
                n_stage   = '0;
                n_pending = '0;
                n_used    = '0;
                out_load  = 1'b1;
            end
            default: ;
        endcase

        // Register write: the user must write only while idle, not enforced here; it always restarts the ring empty
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_CAPACITY: n_cap_cfg = CAP_CFG_W'(i_cfg_data);
                CFG_IDX_CHANNELS: n_ch_cfg  = CH_CFG_W'(i_cfg_data);
                default: ;
            endcase
            n_wr_idx  = '0;
            n_rd_idx  = '0;
            n_stage   = '0;
            n_pending = '0;
            n_used    = '0;
        end

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg     <= CAP_CFG_RESET;
            r_ch_cfg      <= CH_CFG_RESET;
            r_wr_idx      <= '0;
            r_rd_idx      <= '0;
            r_stage       <= '0;
            r_pos         <= '0;
            r_pending     <= '0;
            r_remain      <= '0;
            r_open_frames <= '0;
            r_rd_n        <= '0;
            r_used        <= '0;
            r_consume     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cap_cfg     <= n_cap_cfg;
            r_ch_cfg      <= n_ch_cfg;
            r_wr_idx      <= n_wr_idx;
            r_rd_idx      <= n_rd_idx;
            r_stage       <= n_stage;
            r_pos         <= n_pos;
            r_pending     <= n_pending;
            r_remain      <= n_remain;
            r_open_frames <= n_open_frames;
            r_rd_n        <= n_rd_n;
            r_used        <= n_used;
            r_consume     <= n_consume;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_frames_done  <= n_frames_done;
            r_sample_res   <= n_sample_res;
            r_sample_valid <= n_sample_valid;
            r_last         <= n_last;
            r_status       <= n_status;
        end
    end

    mff_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_stage),
        .i_wdata (i_sample),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_sts.out_free      = !r_out_valid || i_out_ready;
    assign o_sts.pending_zero  = (r_pending == '0);
    assign o_sts.avail_zero    = (rd_n == '0);
    assign o_sts.remaining_one = (r_remain == PW'(1));

    assign o_out_valid    = r_out_valid;
    assign o_frames_done  = r_frames_done;
    assign o_sample_res   = r_sample_res;
    assign o_sample_valid = r_sample_valid;
    assign o_last         = r_last;
    assign o_status       = r_status;

`ifndef SYNTHESIS
    // one frame always stays free
    a_used_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) < 32'(eff_cap))
        else $error("frame occupancy reached capacity");

    a_read_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rd_idx) < 32'(ring))
        else $error("read pointer outside ring");

    a_open_write_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != '0) |-> (r_open_frames != '0))
        else $error("open write with no frames to commit");

    a_run_not_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == OP_RD_NEXT) |-> (r_remain > PW'(1)))
        else $error("sample run continued past its end");

    a_run_start_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == OP_READ_START || i_ctl.op == OP_PEEK_START)
            |=> (r_remain != '0 && r_rd_n != '0))
        else $error("sample run started empty");
`endif

endmodule

### rtl/multichannel_frame_fifo_core.sv
// ----------------------------------------------------------------------------
// multichannel_frame_fifo_core
// Ring FIFO of 32-bit samples in interleaved frames, with write-begin,
// sample, read, peek and clear requests.
// ----------------------------------------------------------------------------
// Every request except read and peek gives one result and, with the result
// side ready, one request is taken per clock. A read or peek that moves N
// frames gives N x channels samples: the request is taken, the first word
// comes from the store in the following clock, then one sample per clock while the
// result side is ready; the store's single registered read port sets this
// pace, and no new request is taken until the last sample of the run is in
// the result register. Register writes empty the ring at once; the store
// needs no clearing pass after reset.
module multichannel_frame_fifo_core #(
    parameter int CAPACITY_FRAMES    = 1024,
    parameter int MAX_CHANNELS       = 2,
    parameter int MAX_REQUEST_FRAMES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mff_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mff_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mff_pkg::CMD_W-1:0]        i_command,
    input  logic [mff_pkg::FRAME_W-1:0]      i_frame_count,
    input  logic [mff_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mff_pkg::FRAME_W-1:0]      o_frames_done,
    output logic [mff_pkg::SAMPLE_W-1:0]     o_sample_res,
    output logic                             o_sample_valid,
    output logic                             o_last,
    output logic                             o_status
);
    import mff_pkg::*;

    t_ctl ctl;
    t_sts sts;

    mff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    mff_dp #(
        .CAPACITY_FRAMES    (CAPACITY_FRAMES),
        .MAX_CHANNELS       (MAX_CHANNELS),
        .MAX_REQUEST_FRAMES (MAX_REQUEST_FRAMES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_frame_count  (i_frame_count),
        .i_sample       (i_sample),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frames_done  (o_frames_done),
        .o_sample_res   (o_sample_res),
        .o_sample_valid (o_sample_valid),
        .o_last         (o_last),
        .o_status       (o_status)
    );

endmodule
